[rtl/core/deq_pkg.sv]
// Shared types and codes for the double-ended queue core.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package deq_pkg;

	localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_LIST_BACK  = 3'd4;
	localparam logic [2:0] MODE_LIST_FRONT = 3'd5;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] key_out;
		logic [4:0]         entry_count;
		logic [1:0]         status;
		logic               last;
	} out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       push_back;
		logic       push_front;
		logic       pop_front;
		logic       pop_back;
		logic       load_list;
		logic       list_back;
		logic       list_rd;
		logic       cnt_inc;
		logic       out_mem;
		logic       out_imm;
		logic [1:0] imm_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic last;
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/deq_dpath.sv]
// Datapath of the double-ended queue: entry memory, front pointer, occupancy,
// listing counter and the result register. Depends on deq_pkg.
`default_nettype none

module deq_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire deq_pkg::cmd_t       cmd,
	input  wire logic signed [31:0]  value,
	output deq_pkg::stat_t           stat,
	output deq_pkg::out_t            out_data
);
	import deq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

	function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
		logic [IW:0] r;
		r = (s >= DEPTH_W) ? s - DEPTH_W : s;
		return r[IW-1:0];
	endfunction

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	logic [IW-1:0] front_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] occ_d;
	logic [IW-1:0] cnt_q;
	logic          list_q;
	logic          back_q;

	logic signed [31:0] key_q;
	logic [4:0]         count_q;
	logic [1:0]         status_q;
	logic               last_q;

	logic [IW-1:0] back_addr;
	logic [IW-1:0] tail_addr;
	logic [IW-1:0] prev_front;
	logic [IW-1:0] next_front;
	logic [CW-1:0] occ_m1;
	logic [CW-1:0] list_off;
	logic [IW-1:0] list_addr;
	logic [IW-1:0] waddr;
	logic [IW-1:0] raddr;
	logic          list_last;
	logic [CW+4:0] occ_ext;

	assign occ_m1     = occ_q - 1'b1;
	assign back_addr  = wrap({1'b0, front_q} + (IW + 1)'(occ_q));
	assign tail_addr  = wrap({1'b0, front_q} + (IW + 1)'(occ_m1));
	assign prev_front = (front_q == '0) ? LAST_IX : front_q - 1'b1;
	assign next_front = wrap({1'b0, front_q} + 1'b1);
	assign list_off   = back_q ? occ_m1 - CW'(cnt_q) : CW'(cnt_q);
	assign list_addr  = wrap({1'b0, front_q} + (IW + 1)'(list_off));
	assign list_last  = (CW'(cnt_q) + 1'b1) == occ_q;

	assign waddr = cmd.push_front ? prev_front : back_addr;

	always_comb begin
		raddr = list_addr;
		if (cmd.pop_front) begin
			raddr = front_q;
		end else if (cmd.pop_back) begin
			raddr = tail_addr;
		end
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.push_back || cmd.push_front) begin
			occ_d = occ_q + 1'b1;
		end else if (cmd.pop_front || cmd.pop_back) begin
			occ_d = occ_m1;
		end
	end

	// The count field is the occupancy cut to five bits.
	assign occ_ext = {5'b0, occ_d};

	always_ff @(posedge clk) begin
		if (cmd.push_back || cmd.push_front) begin
			mem[waddr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_front || cmd.pop_back || cmd.list_rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
			cnt_q   <= '0;
			list_q  <= 1'b0;
			back_q  <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (cmd.push_front) begin
				front_q <= prev_front;
			end else if (cmd.pop_front) begin
				front_q <= next_front;
			end
			if (cmd.load_list) begin
				list_q <= 1'b1;
				back_q <= cmd.list_back;
				cnt_q  <= '0;
			end else if (cmd.pop_front || cmd.pop_back) begin
				list_q <= 1'b0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_imm) begin
			key_q    <= '0;
			count_q  <= occ_ext[4:0];
			status_q <= cmd.imm_status;
			last_q   <= 1'b1;
		end else if (cmd.out_mem) begin
			key_q    <= rdata_q;
			count_q  <= occ_ext[4:0];
			status_q <= STATUS_OK;
			last_q   <= !list_q || list_last;
		end
	end

	assign stat.full  = (occ_q == DEPTH_C);
	assign stat.empty = (occ_q == '0);
	assign stat.last  = last_q;

	assign out_data.key_out     = key_q;
	assign out_data.entry_count = count_q;
	assign out_data.status      = status_q;
	assign out_data.last        = last_q;

endmodule

`default_nettype wire

[rtl/core/deq_ctrl.sv]
// Controller of the double-ended queue: decodes each request and sequences
// memory reads and result delivery. Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [2:0]     mode,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire deq_pkg::stat_t stat,
	output deq_pkg::cmd_t       cmd
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_PUSH_BACK, MODE_PUSH_FRONT: state_d = S_OUT;
						MODE_POP_FRONT, MODE_POP_BACK:   state_d = stat.empty ? S_OUT : S_LOAD;
						MODE_LIST_BACK, MODE_LIST_FRONT: state_d = stat.empty ? S_OUT : S_READ;
						default:                         state_d = S_IDLE;
					endcase
				end
			end
			S_READ: state_d = S_LOAD;
			S_LOAD: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) begin
					state_d = stat.last ? S_IDLE : S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
							cmd.out_imm = 1'b1;
							if (stat.full) begin
								cmd.imm_status = STATUS_FULL;
							end else begin
								cmd.imm_status = STATUS_OK;
								cmd.push_back  = (mode == MODE_PUSH_BACK);
								cmd.push_front = (mode == MODE_PUSH_FRONT);
							end
						end
						MODE_POP_FRONT, MODE_POP_BACK: begin
							if (stat.empty) begin
								cmd.out_imm    = 1'b1;
								cmd.imm_status = STATUS_EMPTY;
							end else begin
								cmd.pop_front = (mode == MODE_POP_FRONT);
								cmd.pop_back  = (mode == MODE_POP_BACK);
							end
						end
						MODE_LIST_BACK, MODE_LIST_FRONT: begin
							if (stat.empty) begin
								cmd.out_imm    = 1'b1;
								cmd.imm_status = STATUS_EMPTY;
							end else begin
								cmd.load_list = 1'b1;
								cmd.list_back = (mode == MODE_LIST_BACK);
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			S_READ: cmd.list_rd = 1'b1;
			S_LOAD: cmd.out_mem = 1'b1;
			S_OUT: begin
				// Step to the next entry once a listing result has been taken.
				if (out_ready && !stat.last) begin
					cmd.cnt_inc = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
// Top level of the double-ended queue core: joins controller and datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// A double-ended queue of DEPTH signed 32-bit keys in a circular buffer held
// in a single-port-write, registered-read memory. One request is handled at a
// time: the next request is taken once the last result of the current one has
// been taken. A push, or any request refused because the queue is full or
// empty, is accepted and then gives its result; a pop first passes through
// the registered memory read and the result register; a listing of N entries
// revisits the memory read and the result register for each entry. Requests
// with an undefined mode are consumed and give no result.
`default_nettype none

module double_ended_queue_core #(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire deq_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output deq_pkg::out_t     out_data
);
	import deq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (in_data.mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (in_data.value),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

[rtl/core/deq_checker.sv]
// Port-level checks for the double-ended queue core, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core.
`default_nettype none

module deq_checker #(
	parameter int DEPTH = 16
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire deq_pkg::out_t out_data
);
	import deq_pkg::*;

	localparam logic [4:0] FULL_CNT = 5'(DEPTH);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only one request is in flight: none is taken while a result waits.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("request taken while a result was pending");

	// A refused request gives one final result with a zero key.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_OK |-> out_data.last && out_data.key_out == 0)
		else $error("refused request with non-zero key or not last");

	// Full and empty reports agree with the count shown.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status != STATUS_FULL || out_data.entry_count == FULL_CNT) &&
			(out_data.status != STATUS_EMPTY || out_data.entry_count == 5'd0))
		else $error("status disagrees with entry count");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire
